// ===== design/sorted_key_table_engine_assert.svh =====
// Assertion macros used by the sorted key table engine datapath.
// Depends on nothing; bodies are empty when SYNTH is defined.
`ifndef SORTED_KEY_TABLE_ENGINE_ASSERT_SVH
`define SORTED_KEY_TABLE_ENGINE_ASSERT_SVH
`ifndef SYNTH
`define SKE_ASSERT(lbl, clk_i, rst_ni, prop, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SKE_ASSERT_NEVER(lbl, clk_i, rst_ni, expr, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define SKE_ASSERT(lbl, clk_i, rst_ni, prop, msg)
`define SKE_ASSERT_NEVER(lbl, clk_i, rst_ni, expr, msg)
`endif
`endif

// ===== design/ske_pkg.sv =====
// Types, codes and default sizes of the sorted key table engine.
// Used by the controller, the datapath and the top level.
package ske_pkg;

	localparam int TABLE_DEPTH_DEF = 256;
	localparam int KEY_WIDTH_DEF   = 32;
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int INDEX_WIDTH     = 8;
	localparam int MODE_WIDTH      = 3;

	typedef enum logic [2:0] {
		OP_GET     = 3'd0,
		OP_SET     = 3'd1,
		OP_INSERT  = 3'd2,
		OP_REMOVE  = 3'd3,
		OP_GET_INS = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_MISSING = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		RES_MISS,
		RES_FULL,
		RES_STORED,
		RES_NEW
	} res_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_CMP,
		S_DECIDE,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_PUT,
		S_OUT
	} state_t;

	typedef struct packed {
		logic accept;
		logic probe_rd;
		logic probe_cmp;
		logic shift_init;
		logic shift_up;
		logic sh_rd;
		logic sh_wr;
		logic wr_entry;
		logic cnt_inc;
		logic cnt_dec;
		logic load_out;
		res_t res;
	} cmd_t;

	typedef struct packed {
		logic search_more;
		logic hit;
		op_t  op;
		logic full;
		logic shift_more;
		logic shift_up;
		logic out_free;
	} dp_status_t;

	function automatic op_t decode_op(logic [MODE_WIDTH-1:0] mode);
		op_t op;
		case (mode)
			OP_SET:     op = OP_SET;
			OP_INSERT:  op = OP_INSERT;
			OP_REMOVE:  op = OP_REMOVE;
			OP_GET_INS: op = OP_GET_INS;
			default:    op = OP_GET;
		endcase
		return op;
	endfunction

endpackage

// ===== design/sorted_key_table_engine.sv =====
// Sorted key table engine: a key/value table kept in ascending key order.
// Request channel s_*: s_tuser carries mode, s_tdata carries key_hash then value.
// Result channel m_*: m_tuser carries status then found, m_tdata index then value_out.
// One result comes back for every accepted request, in request order.
// A lookup is a binary search over the n stored entries, followed by decode,
// write back and hand-off. Insert and remove also move every later entry
// through the table RAM, one read and one write per moved entry. One request
// is in flight at a time.
// The finished result sits in an output register; the next request is accepted
// while it waits, and the block holds in its result step if the receiver stalls.
// cfg_we/cfg_wdata set the value that get-or-insert stores for a missing key.
// Reset empties the table and clears that value to zero; no clearing pass runs.
// Depends on ske_pkg, ske_ctrl and ske_dp.
module sorted_key_table_engine
	import ske_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [VALUE_WIDTH-1:0] cfg_wdata,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// [2:0] mode
	input  logic [MODE_WIDTH-1:0]  s_tuser,
	// key_hash, value (zero padded to bytes)
	input  logic [((KEY_WIDTH+VALUE_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [1:0] status, [2] found
	output logic [2:0]             m_tuser,
	// index, value_out (zero padded to bytes)
	output logic [((INDEX_WIDTH+VALUE_WIDTH+7)/8)*8-1:0] m_tdata
);

	localparam int M_DW = ((INDEX_WIDTH + VALUE_WIDTH + 7) / 8) * 8;

	cmd_t                   cmd;
	dp_status_t             st;
	status_t                out_status;
	logic                   out_found;
	logic [INDEX_WIDTH-1:0] out_index;
	logic [VALUE_WIDTH-1:0] out_value;

	ske_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.st      (st),
		.cmd     (cmd)
	);

	ske_dp #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.KEY_WIDTH  (KEY_WIDTH),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_mode  (s_tuser),
		.req_key   (s_tdata[KEY_WIDTH-1:0]),
		.req_value (s_tdata[KEY_WIDTH+VALUE_WIDTH-1:KEY_WIDTH]),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.out_status(out_status),
		.out_found (out_found),
		.out_index (out_index),
		.out_value (out_value)
	);

	assign m_tuser = {out_found, out_status};
	assign m_tdata = M_DW'({out_value, out_index});

endmodule

// ===== design/ske_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module ske_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/ske_ctrl.sv =====
// Controller state machine: search, shift, write back and result hand-off.
// Depends on ske_pkg; drives the datapath through cmd_t, reads dp_status_t.
module ske_ctrl
	import ske_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  dp_status_t st,
	output cmd_t       cmd
);

	state_t state_q, state_d;
	res_t   res_q, res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_q   <= RES_MISS;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		res_d    = res_q;
		cmd      = '0;
		cmd.res  = res_q;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
				if (s_tvalid) begin
					state_d = S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (st.search_more) begin
					cmd.probe_rd = 1'b1;
					state_d      = S_CMP;
				end else begin
					state_d = S_DECIDE;
				end
			end
			S_CMP: begin
				cmd.probe_cmp = 1'b1;
				state_d       = S_SEARCH;
			end
			S_DECIDE: begin
				if (st.hit) begin
					if (st.op inside {OP_SET, OP_INSERT}) begin
						res_d   = RES_NEW;
						state_d = S_PUT;
					end else if (st.op == OP_REMOVE) begin
						res_d          = RES_STORED;
						cmd.shift_init = 1'b1;
						cmd.shift_up   = 1'b0;
						state_d        = S_SHIFT_RD;
					end else begin
						res_d   = RES_STORED;
						state_d = S_OUT;
					end
				end else if (st.op inside {OP_INSERT, OP_GET_INS}) begin
					if (st.full) begin
						res_d   = RES_FULL;
						state_d = S_OUT;
					end else begin
						res_d          = RES_NEW;
						cmd.shift_init = 1'b1;
						cmd.shift_up   = 1'b1;
						state_d        = S_SHIFT_RD;
					end
				end else begin
					res_d   = RES_MISS;
					state_d = S_OUT;
				end
			end
			S_SHIFT_RD: begin
				if (st.shift_more) begin
					cmd.sh_rd = 1'b1;
					state_d   = S_SHIFT_WR;
				end else if (st.shift_up) begin
					state_d = S_PUT;
				end else begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_OUT;
				end
			end
			S_SHIFT_WR: begin
				cmd.sh_wr = 1'b1;
				state_d   = S_SHIFT_RD;
			end
			S_PUT: begin
				cmd.wr_entry = 1'b1;
				cmd.cnt_inc  = !st.hit;
				state_d      = S_OUT;
			end
			S_OUT: begin
				if (st.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== design/ske_dp.sv =====
// Datapath: table RAM, search bounds, shift pointer, entry count, result register.
// Depends on ske_pkg, ske_ram and the assertion macro header.
`include "sorted_key_table_engine_assert.svh"
module ske_dp
	import ske_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	output dp_status_t             st,
	input  logic                   cfg_we,
	input  logic [VALUE_WIDTH-1:0] cfg_wdata,
	input  logic [MODE_WIDTH-1:0]  req_mode,
	input  logic [KEY_WIDTH-1:0]   req_key,
	input  logic [VALUE_WIDTH-1:0] req_value,
	input  logic                   m_tready,
	output logic                   m_tvalid,
	output status_t                out_status,
	output logic                   out_found,
	output logic [INDEX_WIDTH-1:0] out_index,
	output logic [VALUE_WIDTH-1:0] out_value
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int EW = KEY_WIDTH + VALUE_WIDTH;

	logic [CW-1:0]          count_q, lo_q, hi_q, j_q;
	logic                   up_q, hit_q, m_valid_q;
	op_t                    op_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [VALUE_WIDTH-1:0] val_q, stored_q, default_q;

	logic [CW:0]            sum;
	logic [CW-1:0]          mid, j_plus, j_minus;
	logic [CW+INDEX_WIDTH-1:0] pos_ext;
	logic [EW-1:0]          rdata, wdata;
	logic [KEY_WIDTH-1:0]   rd_key;
	logic [VALUE_WIDTH-1:0] rd_val, new_val;
	logic [AW-1:0]          raddr, waddr;
	logic                   re, we, out_free;

	assign sum     = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = sum[CW:1];
	assign j_plus  = j_q + 1'b1;
	assign j_minus = j_q - 1'b1;
	assign rd_key  = rdata[KEY_WIDTH-1:0];
	assign rd_val  = rdata[EW-1:KEY_WIDTH];
	assign new_val = (op_q == OP_GET_INS) ? default_q : val_q;
	assign pos_ext = (CW + INDEX_WIDTH)'(lo_q);

	assign re    = cmd.probe_rd | cmd.sh_rd;
	assign raddr = cmd.probe_rd ? mid[AW-1:0] : (up_q ? j_minus[AW-1:0] : j_plus[AW-1:0]);
	assign we    = cmd.sh_wr | cmd.wr_entry;
	assign waddr = cmd.wr_entry ? lo_q[AW-1:0] : j_q[AW-1:0];
	assign wdata = cmd.wr_entry ? {new_val, key_q} : rdata;

	ske_ram #(
		.WIDTH(EW),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign out_free = !m_valid_q || m_tready;

	always_comb begin
		st.search_more = lo_q < hi_q;
		st.hit         = hit_q;
		st.op          = op_q;
		st.full        = count_q == CW'(TABLE_DEPTH);
		st.shift_more  = up_q ? (j_q > lo_q) : (j_plus < count_q);
		st.shift_up    = up_q;
		st.out_free    = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			lo_q      <= '0;
			hi_q      <= '0;
			j_q       <= '0;
			up_q      <= 1'b0;
			hit_q     <= 1'b0;
			op_q      <= OP_GET;
			default_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				default_q <= cfg_wdata;
			end
			if (cmd.accept) begin
				op_q  <= decode_op(req_mode);
				lo_q  <= '0;
				hi_q  <= count_q;
				hit_q <= 1'b0;
			end
			if (cmd.probe_cmp) begin
				if (rd_key < key_q) begin
					lo_q <= mid + 1'b1;
				end else begin
					hi_q  <= mid;
					hit_q <= rd_key == key_q;
				end
			end
			if (cmd.shift_init) begin
				j_q  <= cmd.shift_up ? count_q : lo_q;
				up_q <= cmd.shift_up;
			end else if (cmd.sh_wr) begin
				j_q <= up_q ? j_minus : j_plus;
			end
			if (cmd.cnt_inc) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - 1'b1;
			end
			if (cmd.load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			key_q <= req_key;
			val_q <= req_value;
		end
		if (cmd.probe_cmp && !(rd_key < key_q)) begin
			stored_q <= rd_val;
		end
		if (cmd.load_out) begin
			case (cmd.res)
				RES_STORED: begin
					out_status <= ST_OK;
					out_found  <= 1'b1;
					out_index  <= pos_ext[INDEX_WIDTH-1:0];
					out_value  <= stored_q;
				end
				RES_NEW: begin
					out_status <= ST_OK;
					out_found  <= hit_q;
					out_index  <= pos_ext[INDEX_WIDTH-1:0];
					out_value  <= new_val;
				end
				RES_FULL: begin
					out_status <= ST_FULL;
					out_found  <= 1'b0;
					out_index  <= '0;
					out_value  <= '0;
				end
				default: begin
					out_status <= ST_MISSING;
					out_found  <= 1'b0;
					out_index  <= '0;
					out_value  <= '0;
				end
			endcase
		end
	end

	assign m_tvalid = m_valid_q;

	`SKE_ASSERT_NEVER(a_count_range, clk, arst_n, count_q > CW'(TABLE_DEPTH), "entry count above depth")
	`SKE_ASSERT_NEVER(a_bounds_order, clk, arst_n, lo_q > hi_q, "search bounds crossed")
	`SKE_ASSERT(a_load_free, clk, arst_n, cmd.load_out |-> out_free, "result loaded over pending one")
	`SKE_ASSERT(a_count_inc, clk, arst_n, cmd.cnt_inc |=> count_q == $past(count_q) + 1'b1, "count did not advance")

endmodule

// ===== dv/ske_table_monitor.sv =====
// Result checker for the sorted key table engine: watches the request, result and
// config channels, keeps its own sorted key/value table and compares every result.
// Depends on ske_pkg for the mode and status codes and the default field widths.
`timescale 1ns / 100ps

module ske_table_monitor
	import ske_pkg::*;
#(
	parameter int DEPTH    = TABLE_DEPTH_DEF,
	parameter int S_DATA_W = ((KEY_WIDTH_DEF + VALUE_WIDTH_DEF + 7) / 8) * 8,
	parameter int M_DATA_W = ((INDEX_WIDTH + VALUE_WIDTH_DEF + 7) / 8) * 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [VALUE_WIDTH_DEF-1:0] cfg_wdata,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	input  logic [MODE_WIDTH-1:0]      s_tuser,
	input  logic [S_DATA_W-1:0]        s_tdata,
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	input  logic [2:0]                 m_tuser,
	input  logic [M_DATA_W-1:0]        m_tdata,
	output int                         error_count,
	output int                         outstanding
);

	typedef struct packed {
		status_t                    status;
		logic                       found;
		logic [INDEX_WIDTH-1:0]     index;
		logic [VALUE_WIDTH_DEF-1:0] value;
	} table_rsp_t;

	logic [KEY_WIDTH_DEF-1:0]   key_tab[DEPTH];
	logic [VALUE_WIDTH_DEF-1:0] val_tab[DEPTH];
	int                         entries;
	logic [VALUE_WIDTH_DEF-1:0] default_val;
	table_rsp_t                 awaited_rsp_q[$];
	int                         rsp_seen;

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ns: result %0d, %s: got %0h, want %0h", $time, rsp_seen, field, got,
			want);
		error_count++;
	endtask

	// Search, then apply the request to the table; returns the result it must produce.
	function automatic table_rsp_t lookup_and_update(logic [MODE_WIDTH-1:0] mode_bits,
			logic [KEY_WIDTH_DEF-1:0] key, logic [VALUE_WIDTH_DEF-1:0] value);
		op_t                        op;
		int                         lo;
		int                         hi;
		int                         mid;
		int                         i;
		bit                         hit;
		logic [VALUE_WIDTH_DEF-1:0] stored;
		table_rsp_t                 rsp;

		op = (mode_bits > OP_GET_INS) ? OP_GET : op_t'(mode_bits);
		lo = 0;
		hi = entries;
		while (lo < hi) begin
			mid = (lo + hi) / 2;
			if (key_tab[mid] < key)
				lo = mid + 1;
			else
				hi = mid;
		end
		hit = (lo < entries) && (key_tab[lo] == key);
		rsp.status = ST_MISSING;
		rsp.found  = 1'b0;
		rsp.index  = '0;
		rsp.value  = '0;

		if (hit) begin
			rsp.status = ST_OK;
			rsp.found  = 1'b1;
			rsp.index  = lo[INDEX_WIDTH-1:0];
			if (op == OP_REMOVE) begin
				rsp.value = val_tab[lo];
				for (i = lo; i + 1 < entries; i++) begin
					key_tab[i] = key_tab[i + 1];
					val_tab[i] = val_tab[i + 1];
				end
				entries--;
			end else begin
				if (op == OP_SET || op == OP_INSERT)
					val_tab[lo] = value;
				rsp.value = val_tab[lo];
			end
		end else if (op == OP_INSERT || op == OP_GET_INS) begin
			stored = (op == OP_INSERT) ? value : default_val;
			if (entries >= DEPTH) begin
				rsp.status = ST_FULL;
			end else begin
				for (i = entries; i > lo; i--) begin
					key_tab[i] = key_tab[i - 1];
					val_tab[i] = val_tab[i - 1];
				end
				key_tab[lo] = key;
				val_tab[lo] = stored;
				entries++;
				rsp.status = ST_OK;
				rsp.index  = lo[INDEX_WIDTH-1:0];
				rsp.value  = stored;
			end
		end
		return rsp;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		table_rsp_t want;
		table_rsp_t got;

		if (!arst_n) begin
			entries     = 0;
			default_val = '0;
			error_count = 0;
			rsp_seen    = 0;
			awaited_rsp_q.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we)
				default_val = cfg_wdata;
			if (s_tvalid && s_tready)
				awaited_rsp_q.push_back(lookup_and_update(s_tuser,
					s_tdata[KEY_WIDTH_DEF-1:0],
					s_tdata[KEY_WIDTH_DEF+VALUE_WIDTH_DEF-1:KEY_WIDTH_DEF]));
			if (m_tvalid && m_tready) begin
				got.status = status_t'(m_tuser[1:0]);
				got.found  = m_tuser[2];
				got.index  = m_tdata[INDEX_WIDTH-1:0];
				got.value  = m_tdata[INDEX_WIDTH+VALUE_WIDTH_DEF-1:INDEX_WIDTH];
				if (awaited_rsp_q.size() == 0) begin
					report_mismatch("result with no request", got.value, '0);
				end else begin
					want = awaited_rsp_q.pop_front();
					if (got.status !== want.status)
						report_mismatch("status", got.status, want.status);
					if (got.found !== want.found)
						report_mismatch("found", got.found, want.found);
					if (got.index !== want.index)
						report_mismatch("index", got.index, want.index);
					if (got.value !== want.value)
						report_mismatch("value_out", got.value, want.value);
				end
				rsp_seen++;
			end
			outstanding <= awaited_rsp_q.size();
		end
	end

endmodule

// ===== dv/tb_top.sv =====
// Top of the sorted key table engine testbench: clock, reset, request stimulus,
// receiver back-pressure and the verdict. Depends on ske_pkg, the engine RTL and
// ske_table_monitor, which predicts and checks every result.
`timescale 1ns / 100ps

module tb_top;
	import ske_pkg::*;

	localparam int S_DATA_W    = ((KEY_WIDTH_DEF + VALUE_WIDTH_DEF + 7) / 8) * 8;
	localparam int M_DATA_W    = ((INDEX_WIDTH + VALUE_WIDTH_DEF + 7) / 8) * 8;
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int POOL_MAX    = 1024;

	localparam logic [MODE_WIDTH-1:0] MODE_UNUSED_FIRST = 3'd5;
	localparam logic [MODE_WIDTH-1:0] MODE_UNUSED_LAST  = 3'd7;

	logic                       clk;
	logic                       arst_n    = 1'b0;
	logic                       cfg_we    = 1'b0;
	logic [VALUE_WIDTH_DEF-1:0] cfg_wdata = '0;
	logic                       s_tvalid  = 1'b0;
	logic                       s_tready;
	logic [MODE_WIDTH-1:0]      s_tuser   = '0;
	logic [S_DATA_W-1:0]        s_tdata   = '0;
	logic                       m_tvalid;
	logic                       m_tready  = 1'b0;
	logic [2:0]                 m_tuser;
	logic [M_DATA_W-1:0]        m_tdata;

	int                         error_count;
	int                         outstanding;
	int                         cycle_cnt      = 0;
	int                         send_idle_pct  = 0;
	int                         recv_stall_pct = 0;
	logic [KEY_WIDTH_DEF-1:0]   key_pool[$];

	sorted_key_table_engine u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tuser  (m_tuser),
		.m_tdata  (m_tdata)
	);

	ske_table_monitor u_table_monitor (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tuser    (s_tuser),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tuser    (m_tuser),
		.m_tdata    (m_tdata),
		.error_count(error_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n)
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic logic [KEY_WIDTH_DEF-1:0] pick_key(int fresh_pct);
		if (key_pool.size() == 0 || $urandom_range(99) < fresh_pct) begin
			case ($urandom_range(19))
				0:       return '0;
				1:       return '1;
				2:       return {1'b1, {(KEY_WIDTH_DEF-1){1'b0}}};
				default: return $urandom;
			endcase
		end
		return key_pool[$urandom_range(key_pool.size() - 1)];
	endfunction

	task automatic send_request(logic [MODE_WIDTH-1:0] mode_bits,
			logic [KEY_WIDTH_DEF-1:0] key, logic [VALUE_WIDTH_DEF-1:0] value);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode_bits;
		s_tdata  <= {value, key};
		do
			@(posedge clk);
		while (!s_tready);
		if (key_pool.size() >= POOL_MAX)
			void'(key_pool.pop_front());
		key_pool.push_back(key);
	endtask

	// Drop valid, wait for every result, then write the default value.
	task automatic configure_default(logic [VALUE_WIDTH_DEF-1:0] dflt);
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= dflt;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_random(int count, int insert_pct, int remove_pct, int fresh_pct);
		int                       r;
		logic [MODE_WIDTH-1:0]    mode_bits;
		logic [KEY_WIDTH_DEF-1:0] key;

		repeat (count) begin
			r = $urandom_range(99);
			if (r < 3)
				mode_bits = $urandom_range(MODE_UNUSED_LAST, MODE_UNUSED_FIRST);
			else if (r < 3 + insert_pct)
				mode_bits = ($urandom_range(3) == 0) ? OP_GET_INS : OP_INSERT;
			else if (r < 3 + insert_pct + remove_pct)
				mode_bits = OP_REMOVE;
			else
				mode_bits = $urandom_range(1) ? OP_SET : OP_GET;
			if (mode_bits == OP_INSERT || mode_bits == OP_GET_INS)
				key = pick_key(fresh_pct);
			else
				key = pick_key(10);
			send_request(mode_bits, key, $urandom);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, default value still at reset
		send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
		send_request(OP_SET, 32'hFFFF_FFFF, 32'h0000_0001);
		send_request(OP_REMOVE, 32'h8000_0000, 32'hFFFF_FFFF);
		send_request(MODE_UNUSED_LAST, 32'h0000_0005, 32'h1234_5678);
		send_request(OP_GET_INS, 32'h0000_1234, 32'hFFFF_FFFF);
		configure_default(32'hFFFF_FFFF);

		send_request(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
		send_request(OP_INSERT, 32'h8000_0000, 32'h5555_5555);
		send_request(OP_INSERT, 32'h8000_0000, 32'hAAAA_AAAA);
		send_request(OP_GET_INS, 32'h7FFF_FFFF, 32'h0000_0000);
		send_request(OP_GET_INS, 32'h7FFF_FFFF, 32'h0000_0000);
		send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
		send_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		send_request(OP_SET, 32'h0000_1234, 32'h0F0F_0F0F);
		send_request(OP_SET, 32'h0000_1235, 32'hF0F0_F0F0);
		send_request(MODE_UNUSED_FIRST, 32'h8000_0000, 32'h0000_0000);
		send_request(MODE_UNUSED_LAST, 32'h0000_1234, 32'hDEAD_BEEF);
		send_request(OP_REMOVE, 32'h8000_0000, 32'h0000_0000);
		send_request(OP_REMOVE, 32'h8000_0000, 32'h0000_0000);
		send_request(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
		send_request(OP_REMOVE, 32'h0000_0000, 32'h0000_0000);
		send_request(OP_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
		send_request(OP_INSERT, 32'h0000_0001, 32'h0000_0000);
		send_request(OP_GET, 32'h0000_0001, 32'h0000_0000);

		configure_default(32'h0000_0000);
		run_random(250, 35, 22, 60);

		configure_default($urandom);
		send_idle_pct = 72;
		run_random(340, 88, 3, 90);

		configure_default($urandom);
		send_idle_pct = 0;
		recv_stall_pct <= 72;
		run_random(280, 45, 40, 50);

		configure_default($urandom);
		send_idle_pct = 37;
		recv_stall_pct <= 37;
		run_random(280, 15, 65, 10);

		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (32) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/ske_pkg.sv
design/ske_ram.sv
design/ske_ctrl.sv
design/ske_dp.sv
design/sorted_key_table_engine.sv
dv/ske_table_monitor.sv
dv/tb_top.sv
